// File: design/scaled_colorkey_bitmap_blitter_top_macros.svh
// assertion macros for the blitter controller
// no dependencies; included by scbb_ctrl, the only file that checks its own logic
`ifndef SCALED_COLORKEY_BITMAP_BLITTER_TOP_MACROS_SVH
`define SCALED_COLORKEY_BITMAP_BLITTER_TOP_MACROS_SVH

// same-cycle implication
`define SCBB_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scbb check failed");

// next-cycle implication
`define SCBB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scbb check failed");

`endif

// File: design/scbb_pkg.sv
// shared types and constants of the scaled color-key blitter
// no dependencies; used by scbb_ctrl, scbb_dp and the top level
package scbb_pkg;

   localparam int MAX_SIDE  = 256;
   localparam int MAX_ZOOM  = 8;

   localparam int OriginW   = 12;
   localparam int SideW     = 9;
   localparam int ZoomRegW  = 4;
   localparam int ColorW    = 16;
   localparam int CoordW    = 13;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 16;

   localparam int CntW      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SubW      = (MAX_ZOOM > 1) ? $clog2(MAX_ZOOM) : 1;
   localparam int SideClamp = (MAX_SIDE > (2 ** SideW) - 1) ? (2 ** SideW) - 1 : MAX_SIDE;
   localparam int ProdW     = CntW + ZoomRegW;

   // register indexes
   localparam logic [CsrIdxW-1:0] REG_ORIGIN_X   = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_ORIGIN_Y   = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_SRC_WIDTH  = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_SRC_HEIGHT = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_ZOOM       = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_KEY_ENABLE = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_KEY_COLOR  = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_BACK_COLOR = 3'd7;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic draw;
      logic last;
   } sts_type;

endpackage

// File: design/scaled_colorkey_bitmap_blitter_top.sv
// Scaled color-key bitmap blitter, top level.
// Source RGB565 pixels enter on the req_ channel in raster order, one word each.
// Each pixel becomes a zoom by zoom block of screen writes on the rsp_ channel,
// row by row, with rsp_block_last set on the block's final write.
// Configuration (origin, source size, zoom, color key) is written on the csr_
// port by the user only while the block is idle, which the block does not enforce;
// writes take effect at the next clock edge. Latency: the first write of a block
// is valid the cycle after its pixel is taken. Throughput: one output word per
// cycle while not stalled, zoom clamped to 8; the next pixel is taken in the same
// cycle the block's last write is taken, so at zoom one a pixel enters every cycle
// while not stalled. Pixels with zero width, height or zoom produce no writes.
// The write rate is set by the single output register and its sub-position
// counters in the datapath.
// Reset clears the column and row counters and restores the register defaults
// (8x8 source, zoom one, key off, origin zero).
// When rsp_stall is high the current write and its coordinates hold, and no new
// pixel is taken until the block's last write leaves.
// depends on scbb_pkg, scbb_ctrl and scbb_dp
module scaled_colorkey_bitmap_blitter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [scbb_pkg::ColorW-1:0]         req_src_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [scbb_pkg::CoordW-1:0]  rsp_screen_x,
   output logic signed [scbb_pkg::CoordW-1:0]  rsp_screen_y,
   output logic [scbb_pkg::ColorW-1:0]         rsp_out_color,
   output logic                                rsp_block_last,
   input  logic                                csr_we,
   input  logic [scbb_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [scbb_pkg::CsrDataW-1:0]       csr_wdata
);

   scbb_pkg::cmd_type cmd;
   scbb_pkg::sts_type sts;

   scbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   scbb_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_src_pixel  (req_src_pixel),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_screen_x   (rsp_screen_x),
      .rsp_screen_y   (rsp_screen_y),
      .rsp_out_color  (rsp_out_color),
      .rsp_block_last (rsp_block_last)
   );

endmodule

// File: design/scbb_dp.sv
// datapath: config registers, source counters, block coordinates and output word
// depends on scbb_pkg; driven by scbb_ctrl through scbb_pkg::cmd_type
module scbb_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [scbb_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [scbb_pkg::CsrDataW-1:0]       csr_wdata,
   input  logic [scbb_pkg::ColorW-1:0]         req_src_pixel,
   input  scbb_pkg::cmd_type                   cmd,
   output scbb_pkg::sts_type                   sts,
   output logic signed [scbb_pkg::CoordW-1:0]  rsp_screen_x,
   output logic signed [scbb_pkg::CoordW-1:0]  rsp_screen_y,
   output logic [scbb_pkg::ColorW-1:0]         rsp_out_color,
   output logic                                rsp_block_last
);

   logic signed [scbb_pkg::OriginW-1:0] origin_x_ff, origin_y_ff;
   logic [scbb_pkg::SideW-1:0]          width_ff, height_ff;
   logic [scbb_pkg::ZoomRegW-1:0]       zoom_ff;
   logic                                key_en_ff;
   logic [scbb_pkg::ColorW-1:0]         key_color_ff, back_color_ff;

   logic [scbb_pkg::CntW-1:0]           col_ff, col_in, row_ff, row_in;

   logic [scbb_pkg::ColorW-1:0]         color_ff, color_in;
   logic [scbb_pkg::CoordW-1:0]         x_ff, x_in, y_ff, y_in, base_x_ff, base_x_in;
   logic [scbb_pkg::SubW-1:0]           sx_ff, sx_in, sy_ff, sy_in;

   logic [scbb_pkg::SideW-1:0]          w_eff, h_eff;
   logic [scbb_pkg::ZoomRegW-1:0]       z_eff;
   logic [scbb_pkg::SubW-1:0]           zm1;
   logic                                size_zero;
   logic [scbb_pkg::SideW:0]            col_inc, row_inc;
   logic [scbb_pkg::ProdW-1:0]          prod_x, prod_y;
   logic [scbb_pkg::CoordW-1:0]         base_x, base_y;

   always_comb begin
      w_eff = (width_ff > scbb_pkg::SideW'(scbb_pkg::SideClamp)) ?
              scbb_pkg::SideW'(scbb_pkg::SideClamp) : width_ff;
      h_eff = (height_ff > scbb_pkg::SideW'(scbb_pkg::SideClamp)) ?
              scbb_pkg::SideW'(scbb_pkg::SideClamp) : height_ff;
      z_eff = (zoom_ff > scbb_pkg::ZoomRegW'(scbb_pkg::MAX_ZOOM)) ?
              scbb_pkg::ZoomRegW'(scbb_pkg::MAX_ZOOM) : zoom_ff;
      zm1   = scbb_pkg::SubW'(z_eff - scbb_pkg::ZoomRegW'(1));
      size_zero = (width_ff == '0) || (height_ff == '0);

      sts.draw = !size_zero && (zoom_ff != '0);
      sts.last = (sx_ff == zm1) && (sy_ff == zm1);

      // top-left write of the block for the current source position
      prod_x = scbb_pkg::ProdW'(col_ff) * scbb_pkg::ProdW'(z_eff);
      prod_y = scbb_pkg::ProdW'(row_ff) * scbb_pkg::ProdW'(z_eff);
      base_x = {{(scbb_pkg::CoordW - scbb_pkg::OriginW){origin_x_ff[scbb_pkg::OriginW-1]}},
                origin_x_ff} + scbb_pkg::CoordW'(prod_x);
      base_y = {{(scbb_pkg::CoordW - scbb_pkg::OriginW){origin_y_ff[scbb_pkg::OriginW-1]}},
                origin_y_ff} + scbb_pkg::CoordW'(prod_y);

      // raster counters, wrapping also when a size was shrunk below them
      col_inc = (scbb_pkg::SideW+1)'(col_ff) + (scbb_pkg::SideW+1)'(1);
      row_inc = (scbb_pkg::SideW+1)'(row_ff) + (scbb_pkg::SideW+1)'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (cmd.load && !size_zero) begin
         if (col_inc >= {1'b0, w_eff}) begin
            col_in = '0;
            row_in = (row_inc >= {1'b0, h_eff}) ? '0 : scbb_pkg::CntW'(row_inc);
         end else begin
            col_in = scbb_pkg::CntW'(col_inc);
         end
      end

      color_in  = color_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      base_x_in = base_x_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      if (cmd.load) begin
         color_in  = (key_en_ff && (req_src_pixel == key_color_ff)) ? back_color_ff
                                                                    : req_src_pixel;
         x_in      = base_x;
         y_in      = base_y;
         base_x_in = base_x;
         sx_in     = '0;
         sy_in     = '0;
      end else if (cmd.step) begin
         if (sx_ff == zm1) begin
            sx_in = '0;
            x_in  = base_x_ff;
            sy_in = sy_ff + scbb_pkg::SubW'(1);
            y_in  = y_ff + scbb_pkg::CoordW'(1);
         end else begin
            sx_in = sx_ff + scbb_pkg::SubW'(1);
            x_in  = x_ff + scbb_pkg::CoordW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         width_ff      <= scbb_pkg::SideW'(8);
         height_ff     <= scbb_pkg::SideW'(8);
         zoom_ff       <= scbb_pkg::ZoomRegW'(1);
         key_en_ff     <= 1'b0;
         key_color_ff  <= '0;
         back_color_ff <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_we) begin
            unique case (csr_index)
               scbb_pkg::REG_ORIGIN_X:   origin_x_ff   <= csr_wdata[scbb_pkg::OriginW-1:0];
               scbb_pkg::REG_ORIGIN_Y:   origin_y_ff   <= csr_wdata[scbb_pkg::OriginW-1:0];
               scbb_pkg::REG_SRC_WIDTH:  width_ff      <= csr_wdata[scbb_pkg::SideW-1:0];
               scbb_pkg::REG_SRC_HEIGHT: height_ff     <= csr_wdata[scbb_pkg::SideW-1:0];
               scbb_pkg::REG_ZOOM:       zoom_ff       <= csr_wdata[scbb_pkg::ZoomRegW-1:0];
               scbb_pkg::REG_KEY_ENABLE: key_en_ff     <= csr_wdata[0];
               scbb_pkg::REG_KEY_COLOR:  key_color_ff  <= csr_wdata[scbb_pkg::ColorW-1:0];
               scbb_pkg::REG_BACK_COLOR: back_color_ff <= csr_wdata[scbb_pkg::ColorW-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      color_ff  <= color_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      base_x_ff <= base_x_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
   end

   assign rsp_screen_x   = $signed(x_ff);
   assign rsp_screen_y   = $signed(y_ff);
   assign rsp_out_color  = color_ff;
   assign rsp_block_last = sts.last;

endmodule

// File: design/scbb_ctrl.sv
// controller: sequences one source pixel's block of screen writes
// depends on scbb_pkg and the assertion macros header
`include "scaled_colorkey_bitmap_blitter_top_macros.svh"

module scbb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  scbb_pkg::sts_type  sts,
   output scbb_pkg::cmd_type  cmd
);

   scbb_pkg::state_type state_ff, state_in;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scbb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         scbb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.draw) begin
                  state_in = scbb_pkg::ST_EMIT;
               end
            end
         end
         scbb_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            // the next pixel may enter as the block's last word leaves
            req_stall = !(!rsp_stall && sts.last);
            if (!rsp_stall) begin
               if (sts.last) begin
                  state_in = scbb_pkg::ST_IDLE;
                  if (req_valid) begin
                     cmd.load = 1'b1;
                     if (sts.draw) begin
                        state_in = scbb_pkg::ST_EMIT;
                     end
                  end
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   `SCBB_ASSERT_SAME(a_no_accept_mid_block, clock, reset,
      (state_ff == scbb_pkg::ST_EMIT) && !sts.last, req_stall)
   `SCBB_ASSERT_NEXT(a_block_continues, clock, reset,
      cmd.step, state_ff == scbb_pkg::ST_EMIT)
   `SCBB_ASSERT_NEXT(a_nothing_drawn_stays_idle, clock, reset,
      accept && !sts.draw, state_ff == scbb_pkg::ST_IDLE)
   `SCBB_ASSERT_SAME(a_load_only_on_accept, clock, reset,
      cmd.load, accept && !cmd.step)

endmodule

// File: bench/tb_top.sv
// testbench for scaled_colorkey_bitmap_blitter_top: a table of directed pixels and register
// writes, then random phases, each write checked against a behavioral pixel expander or a typed table row
// depends on scbb_pkg and the blitter rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_ITEMS = 300;

   typedef struct packed {
      logic signed [scbb_pkg::CoordW-1:0] x;
      logic signed [scbb_pkg::CoordW-1:0] y;
      logic [scbb_pkg::ColorW-1:0]        color;
      logic                               last;
   } screen_write_type;

   typedef struct packed {
      bit               lit;
      screen_write_type w;
   } item_note_type;

   typedef enum bit {ROW_REG, ROW_PIX} row_kind_type;

   typedef struct {
      row_kind_type                 kind;
      logic [scbb_pkg::CsrIdxW-1:0] idx;
      logic [15:0]                  val;
      bit                           lit;
      int                           x;
      int                           y;
      logic [15:0]                  c;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [scbb_pkg::ColorW-1:0] req_src_pixel = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [scbb_pkg::CoordW-1:0] rsp_screen_x;
   logic signed [scbb_pkg::CoordW-1:0] rsp_screen_y;
   logic [scbb_pkg::ColorW-1:0] rsp_out_color;
   logic rsp_block_last;
   logic csr_we = 1'b0;
   logic [scbb_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [scbb_pkg::CsrDataW-1:0] csr_wdata = '0;

   // shadow of the blitter's registers and raster counters
   logic signed [scbb_pkg::OriginW-1:0] org_x, org_y;
   logic [scbb_pkg::SideW-1:0] width_reg, height_reg;
   logic [scbb_pkg::ZoomRegW-1:0] zoom_reg;
   logic key_on;
   logic [scbb_pkg::ColorW-1:0] key_col, back_col;
   logic [7:0] col_pos, row_pos;

   screen_write_type pending_writes[$];
   item_note_type notes[$];
   int mismatches = 0;
   int cycles = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   plan_row_type plan[] = '{
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h0000, 1, 0, 0, 16'h0000},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'hFFFF, 1, 1, 0, 16'hFFFF},
      '{ROW_REG, scbb_pkg::REG_KEY_ENABLE, 16'h0001, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_KEY_COLOR, 16'hF800, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_BACK_COLOR, 16'h001F, 0, 0, 0, 0},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'hF800, 1, 2, 0, 16'h001F},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'hF801, 1, 3, 0, 16'hF801},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h001F, 1, 4, 0, 16'h001F},
      '{ROW_REG, scbb_pkg::REG_ZOOM, 16'h0008, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_ORIGIN_X, 16'h0800, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_ORIGIN_Y, 16'h07FF, 0, 0, 0, 0},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h1234, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_ZOOM, 16'h000F, 0, 0, 0, 0},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'hF800, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_ZOOM, 16'h0000, 0, 0, 0, 0},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h5555, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_ZOOM, 16'h0001, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_ORIGIN_X, 16'h0000, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_ORIGIN_Y, 16'h0000, 0, 0, 0, 0},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h0F0F, 1, 0, 1, 16'h0F0F},
      '{ROW_REG, scbb_pkg::REG_SRC_WIDTH, 16'h0000, 0, 0, 0, 0},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'hAAAA, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_SRC_WIDTH, 16'h01FF, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_SRC_HEIGHT, 16'hFFFF, 0, 0, 0, 0},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h7777, 1, 1, 1, 16'h7777},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h8888, 1, 2, 1, 16'h8888},
      // width drops below the column counter
      '{ROW_REG, scbb_pkg::REG_SRC_WIDTH, 16'h0002, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_SRC_HEIGHT, 16'h0003, 0, 0, 0, 0},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h1111, 1, 3, 1, 16'h1111},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h2222, 1, 0, 2, 16'h2222},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h3333, 1, 1, 2, 16'h3333},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h4444, 1, 0, 0, 16'h4444},
      '{ROW_REG, scbb_pkg::REG_SRC_HEIGHT, 16'h0000, 0, 0, 0, 0},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'h6666, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_SRC_HEIGHT, 16'h0001, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_KEY_ENABLE, 16'h0000, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_ORIGIN_X, 16'h07FF, 0, 0, 0, 0},
      '{ROW_REG, scbb_pkg::REG_ORIGIN_Y, 16'h0800, 0, 0, 0, 0},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'hF800, 1, 2048, -2048, 16'hF800},
      '{ROW_PIX, scbb_pkg::REG_ORIGIN_X, 16'hFFFF, 1, 2047, -2048, 16'hFFFF}
   };

   scaled_colorkey_bitmap_blitter_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_src_pixel  (req_src_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_screen_x   (rsp_screen_x),
      .rsp_screen_y   (rsp_screen_y),
      .rsp_out_color  (rsp_out_color),
      .rsp_block_last (rsp_block_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int idle_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   // queue the zoom by zoom block of writes for one pixel and move the raster position
   function automatic void expand_pixel(input logic [scbb_pkg::ColorW-1:0] pix);
      int w, h, z, ox, oy, cc, rr;
      logic [scbb_pkg::ColorW-1:0] c;
      screen_write_type sw;
      w = (width_reg > scbb_pkg::MAX_SIDE) ? scbb_pkg::MAX_SIDE : width_reg;
      h = (height_reg > scbb_pkg::MAX_SIDE) ? scbb_pkg::MAX_SIDE : height_reg;
      z = (zoom_reg > scbb_pkg::MAX_ZOOM) ? scbb_pkg::MAX_ZOOM : zoom_reg;
      ox = org_x;
      oy = org_y;
      cc = col_pos;
      rr = row_pos;
      if (w == 0 || h == 0) return;
      c = (key_on && pix == key_col) ? back_col : pix;
      for (int sy = 0; sy < z; sy++) begin
         for (int sx = 0; sx < z; sx++) begin
            sw.x = 13'(ox + cc * z + sx);
            sw.y = 13'(oy + rr * z + sy);
            sw.color = c;
            sw.last = (sy == z - 1) && (sx == z - 1);
            pending_writes.push_back(sw);
         end
      end
      if (cc + 1 >= w) begin
         col_pos = '0;
         row_pos = (rr + 1 >= h) ? 8'd0 : 8'(rr + 1);
      end else begin
         col_pos = 8'(cc + 1);
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatches < 40)
         $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("scaled_colorkey_bitmap_blitter_top verification failed");
         $finish;
      end
   end

   // write side: random stall holds, none started while calm
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         stall_left = idle_len() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      item_note_type note;
      screen_write_type want;
      int n0;
      if (reset) begin
         org_x = '0;
         org_y = '0;
         width_reg = 9'd8;
         height_reg = 9'd8;
         zoom_reg = 4'd1;
         key_on = 1'b0;
         key_col = '0;
         back_col = '0;
         col_pos = '0;
         row_pos = '0;
      end else begin
         // check before queueing: a new word can be taken with the last write of a block
         if (rsp_valid && !rsp_stall) begin
            if (pending_writes.size() == 0) begin
               report_mismatch("write with nothing pending", rsp_screen_x, rsp_screen_y);
            end else begin
               want = pending_writes.pop_front();
               if (rsp_screen_x !== want.x) report_mismatch("screen_x", rsp_screen_x, want.x);
               if (rsp_screen_y !== want.y) report_mismatch("screen_y", rsp_screen_y, want.y);
               if (rsp_out_color !== want.color)
                  report_mismatch("out_color", rsp_out_color, want.color);
               if (rsp_block_last !== want.last)
                  report_mismatch("block_last", rsp_block_last, want.last);
            end
         end
         if (req_valid && !req_stall) begin
            note = notes.pop_front();
            n0 = pending_writes.size();
            expand_pixel(req_src_pixel);
            // typed rows stand in for the computed write
            if (note.lit) begin
               while (pending_writes.size() > n0) void'(pending_writes.pop_back());
               pending_writes.push_back(note.w);
            end
         end
         if (csr_we) begin
            case (csr_index)
               scbb_pkg::REG_ORIGIN_X:   org_x = csr_wdata[scbb_pkg::OriginW-1:0];
               scbb_pkg::REG_ORIGIN_Y:   org_y = csr_wdata[scbb_pkg::OriginW-1:0];
               scbb_pkg::REG_SRC_WIDTH:  width_reg = csr_wdata[scbb_pkg::SideW-1:0];
               scbb_pkg::REG_SRC_HEIGHT: height_reg = csr_wdata[scbb_pkg::SideW-1:0];
               scbb_pkg::REG_ZOOM:       zoom_reg = csr_wdata[scbb_pkg::ZoomRegW-1:0];
               scbb_pkg::REG_KEY_ENABLE: key_on = csr_wdata[0];
               scbb_pkg::REG_KEY_COLOR:  key_col = csr_wdata[scbb_pkg::ColorW-1:0];
               scbb_pkg::REG_BACK_COLOR: back_col = csr_wdata[scbb_pkg::ColorW-1:0];
               default: ;
            endcase
         end
      end
   end

   task automatic send_pixel(input logic [scbb_pkg::ColorW-1:0] pix, input item_note_type note);
      int gap;
      gap = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      notes.push_back(note);
      req_valid <= 1'b1;
      req_src_pixel <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop the request and wait for every block to drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves csr_we high; the caller drops it after the last write
   task automatic set_reg(input logic [scbb_pkg::CsrIdxW-1:0] idx,
                          input logic [scbb_pkg::CsrDataW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   initial begin
      item_note_type note;
      bit in_csr;
      int sent, burst, r;
      logic [15:0] v, pix;
      logic phase_key_on;
      logic [15:0] phase_key;
      in_csr = 1'b0;
      sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REG) begin
            if (!in_csr) settle();
            in_csr = 1'b1;
            set_reg(plan[i].idx, plan[i].val);
         end else begin
            if (in_csr) csr_we <= 1'b0;
            in_csr = 1'b0;
            note.lit = plan[i].lit;
            note.w.x = 13'(plan[i].x);
            note.w.y = 13'(plan[i].y);
            note.w.color = plan[i].c;
            note.w.last = 1'b1;
            send_pixel(plan[i].val, note);
         end
      end

      note = '0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         set_reg(scbb_pkg::REG_ORIGIN_X, 16'($urandom));
         set_reg(scbb_pkg::REG_ORIGIN_Y, 16'($urandom));
         // sizes mostly small, now and then blank or oversized
         for (int k = 0; k < 2; k++) begin
            v = 16'($urandom);
            r = $urandom_range(0, 19);
            v[8:0] = (r == 0) ? 9'd0 : (r < 16) ? 9'($urandom_range(1, 8)) :
                     (r < 18) ? 9'($urandom_range(9, 40)) : 9'($urandom_range(256, 511));
            set_reg(k == 0 ? scbb_pkg::REG_SRC_WIDTH : scbb_pkg::REG_SRC_HEIGHT, v);
         end
         v = 16'($urandom);
         r = $urandom_range(0, 19);
         v[3:0] = (r == 0) ? 4'd0 : (r < 15) ? 4'($urandom_range(1, 3)) :
                  (r < 18) ? 4'($urandom_range(4, 8)) : 4'($urandom_range(9, 15));
         set_reg(scbb_pkg::REG_ZOOM, v);
         v = 16'($urandom);
         phase_key_on = v[0];
         set_reg(scbb_pkg::REG_KEY_ENABLE, v);
         phase_key = 16'($urandom);
         set_reg(scbb_pkg::REG_KEY_COLOR, phase_key);
         set_reg(scbb_pkg::REG_BACK_COLOR, 16'($urandom));
         csr_we <= 1'b0;
         calm = ($urandom_range(0, 4) == 0);
         burst = $urandom_range(6, 30);
         if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
         repeat (burst) begin
            pix = (phase_key_on && $urandom_range(0, 3) == 0) ? phase_key : 16'($urandom);
            send_pixel(pix, note);
            sent++;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("scaled_colorkey_bitmap_blitter_top verification clean");
      end else begin
         $display("scaled_colorkey_bitmap_blitter_top verification failed");
      end
      $finish;
   end

endmodule

// File: scaled_colorkey_bitmap_blitter_top.f
+incdir+design
design/scbb_pkg.sv
design/scbb_dp.sv
design/scbb_ctrl.sv
design/scaled_colorkey_bitmap_blitter_top.sv
bench/tb_top.sv
